// File: rtl/core/kref_pkg.sv
// ----------------------------------------------------------------------------
// kref_pkg
// Shared constants and types for the key reference-count bitmap.
// ----------------------------------------------------------------------------
`default_nettype none

package kref_pkg;

  localparam int unsigned NumKeysDef    = 40;
  localparam int unsigned CountWidthDef = 8;
  localparam int unsigned KeyW          = 6;
  localparam int unsigned MapOutW       = 40;

  localparam logic KindKey   = 1'b0;
  localparam logic KindClear = 1'b1;

  typedef struct packed {
    logic               changed;
    logic [KeyW-1:0]    event_key;
    logic               event_pressed;
    logic [MapOutW-1:0] key_map;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/kref_cnt_mem.sv
// ----------------------------------------------------------------------------
// kref_cnt_mem
// Press counter storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module kref_cnt_mem #(
  parameter int unsigned Depth = kref_pkg::NumKeysDef,
  parameter int unsigned Width = kref_pkg::CountWidthDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/kref_update.sv
// ----------------------------------------------------------------------------
// kref_update
// Counter and bitmap update for one item, plus the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module kref_update #(
  parameter int unsigned NumKeys  = kref_pkg::NumKeysDef,
  parameter int unsigned CountW   = kref_pkg::CountWidthDef,
  parameter int unsigned MapW     = ((NumKeys + 7) / 8) * 8,
  parameter int unsigned MapIdxW  = $clog2(MapW)
) (
  input  wire logic                      kind_i,
  input  wire logic [kref_pkg::KeyW-1:0] key_i,
  input  wire logic                      rel_i,
  input  wire logic [CountW-1:0]         rd_cnt_i,
  input  wire logic                      fwd_vld_i,
  input  wire logic [kref_pkg::KeyW-1:0] fwd_key_i,
  input  wire logic [CountW-1:0]         fwd_cnt_i,
  input  wire logic [MapW-1:0]           map_i,
  output logic                           we_o,
  output logic      [CountW-1:0]         wdata_o,
  output logic      [MapW-1:0]           map_o,
  output kref_pkg::result_t              res_o
);

  localparam logic [kref_pkg::KeyW:0] NumKeysV = (kref_pkg::KeyW + 1)'(NumKeys);
  localparam logic [CountW-1:0]       CountMax = {CountW{1'b1}};

  logic                      in_range;
  logic [kref_pkg::KeyW-1:0] pos;
  logic                      cur_bit;
  logic [CountW-1:0]         cur_cnt;
  logic [CountW-1:0]         cnt;

  // A clear bitmap bit means a zero counter, whatever the storage holds.
  assign in_range = {1'b0, key_i} < NumKeysV;
  assign pos      = {key_i[5:3], ~key_i[2:0]};
  assign cur_bit  = map_i[pos[MapIdxW-1:0]];
  assign cur_cnt  = (fwd_vld_i && (fwd_key_i == key_i)) ? fwd_cnt_i : rd_cnt_i;
  assign cnt      = cur_bit ? cur_cnt : '0;

  always_comb begin
    we_o                = 1'b0;
    wdata_o             = cnt;
    map_o               = map_i;
    res_o.changed       = 1'b0;
    res_o.event_key     = '0;
    res_o.event_pressed = 1'b0;
    if (kind_i == kref_pkg::KindClear) begin
      res_o.changed = |map_i;
      map_o         = '0;
    end else if (in_range) begin
      if (rel_i) begin
        if (cnt != '0) begin
          we_o    = 1'b1;
          wdata_o = cnt - 1'b1;
          if (cnt == CountW'(1)) begin
            if (cur_bit) begin
              res_o.changed   = 1'b1;
              res_o.event_key = key_i;
            end
            map_o[pos[MapIdxW-1:0]] = 1'b0;
          end
        end
      end else begin
        we_o = 1'b1;
        if (cnt == '0) begin
          if (!cur_bit) begin
            res_o.changed       = 1'b1;
            res_o.event_key     = key_i;
            res_o.event_pressed = 1'b1;
          end
          map_o[pos[MapIdxW-1:0]] = 1'b1;
        end
        if (cnt != CountMax) begin
          wdata_o = cnt + 1'b1;
        end
      end
    end
    res_o.key_map = kref_pkg::MapOutW'(map_o);
  end

endmodule

`default_nettype wire

// File: rtl/core/key_refcount_matrix_bitmap.sv
// ----------------------------------------------------------------------------
// key_refcount_matrix_bitmap
// Press reference counters per key folded into a key bitmap.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with kind_i, key_index_i and
// release_req_i. Kind clear zeroes the bitmap and so all counters; a key event
// presses or releases one key, out-of-range keys are ignored.
// Output channel: out_valid_o / out_stall_i with changed_o, event_key_o,
// event_pressed_o and key_map_o (bitmap after the item). One result per item.
// The counter memory is read at the accepting edge alongside the input
// register, and the update lands in the result register when the staged item
// advances. Throughput is one item per cycle while the receiver does not
// stall; the counter written by one item is forwarded to the next item on
// the same key.
// Reset clears the bitmap and all valid flags at once; the bitmap doubles as
// the valid flag of each counter, so counters need no clearing pass.
// When the receiver stalls, the result register holds, the staged item
// waits, and in_stall_o rises once the stage is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module key_refcount_matrix_bitmap #(
  parameter int unsigned NUM_KEYS    = kref_pkg::NumKeysDef,
  parameter int unsigned COUNT_WIDTH = kref_pkg::CountWidthDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         kind_i,
  input  wire logic [kref_pkg::KeyW-1:0]    key_index_i,
  input  wire logic                         release_req_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              changed_o,
  output logic      [kref_pkg::KeyW-1:0]    event_key_o,
  output logic                              event_pressed_o,
  output logic      [kref_pkg::MapOutW-1:0] key_map_o
);

  localparam int unsigned MapW  = ((NUM_KEYS + 7) / 8) * 8;
  localparam int unsigned AddrW = $clog2(NUM_KEYS);

  logic                      stg_vld_q, stg_vld_d;
  logic                      kind_q;
  logic [kref_pkg::KeyW-1:0] key_q;
  logic                      rel_q;
  logic                      fwd_vld_q;
  logic [kref_pkg::KeyW-1:0] fwd_key_q;
  logic [COUNT_WIDTH-1:0]    fwd_cnt_q;
  logic [MapW-1:0]           map_q, map_d;
  logic                      out_vld_q, out_vld_d;
  kref_pkg::result_t         out_q;

  logic                      accept;
  logic                      advance;
  logic                      upd_we;
  logic [COUNT_WIDTH-1:0]    upd_wdata;
  logic [COUNT_WIDTH-1:0]    rd_cnt;
  kref_pkg::result_t         upd_res;

  assign advance    = stg_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = stg_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  kref_cnt_mem #(
    .Depth (NUM_KEYS),
    .Width (COUNT_WIDTH),
    .AddrW (AddrW)
  ) u_cnt_mem (
    .clk_i   (clk_i),
    .we_i    (upd_we && advance),
    .waddr_i (key_q[AddrW-1:0]),
    .wdata_i (upd_wdata),
    .re_i    (accept),
    .raddr_i (key_index_i[AddrW-1:0]),
    .rdata_o (rd_cnt)
  );

  kref_update #(
    .NumKeys (NUM_KEYS),
    .CountW  (COUNT_WIDTH),
    .MapW    (MapW)
  ) u_update (
    .kind_i    (kind_q),
    .key_i     (key_q),
    .rel_i     (rel_q),
    .rd_cnt_i  (rd_cnt),
    .fwd_vld_i (fwd_vld_q),
    .fwd_key_i (fwd_key_q),
    .fwd_cnt_i (fwd_cnt_q),
    .map_i     (map_q),
    .we_o      (upd_we),
    .wdata_o   (upd_wdata),
    .map_o     (map_d),
    .res_o     (upd_res)
  );

  always_comb begin
    stg_vld_d = stg_vld_q;
    if (accept) begin
      stg_vld_d = 1'b1;
    end else if (advance) begin
      stg_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      fwd_vld_q <= 1'b0;
      map_q     <= '0;
    end else begin
      stg_vld_q <= stg_vld_d;
      out_vld_q <= out_vld_d;
      if (accept) begin
        fwd_vld_q <= upd_we && advance;
      end
      if (advance) begin
        map_q <= map_d;
      end
    end
  end

  // Forward the write that lands on the same edge as the memory read.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q    <= kind_i;
      key_q     <= key_index_i;
      rel_q     <= release_req_i;
      fwd_key_q <= key_q;
      fwd_cnt_q <= upd_wdata;
    end
    if (advance) begin
      out_q <= upd_res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign changed_o       = out_q.changed;
  assign event_key_o     = out_q.event_key;
  assign event_pressed_o = out_q.event_pressed;
  assign key_map_o       = out_q.key_map;

`ifndef ASSERT_OFF
  a_stage_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_vld_q && !advance) |=> (stg_vld_q && $stable(key_q) && $stable(kind_q)))
    else $error("staged item lost while stalled");

  a_clear_map : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (kind_q == kref_pkg::KindClear)) |=> (map_q == '0))
    else $error("bitmap not zero after clear");

  a_press_changed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_pressed_o) |-> changed_o)
    else $error("press event without change");
`endif

endmodule

`default_nettype wire
